### rtl/pjt_pkg.sv
// Shared types, codes and constants of the packet sequence and jitter tracker.
package pjt_pkg;

    // One parsed packet header
    typedef struct packed {
        logic [31:0] seq_number;
        logic [63:0] arrival_time_ns;
        logic [10:0] payload_bytes;
        logic [8:0]  sample_count;
        logic [8:0]  channel_count;
        logic [2:0]  sample_type;
        logic [23:0] rate_hz;
    } t_pkt;

    // One result beat
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] lost_total;
        logic [31:0]        next_expected;
        logic [47:0]        mean_interval;
        logic [63:0]        interval_variance;
    } t_res;

    // One register write beat
    typedef struct packed {
        logic [0:0]  index;
        logic [31:0] value;
    } t_cfg;

    localparam logic [0:0] REG_EWMA_ALPHA       = 1'd0;
    localparam logic [0:0] REG_INITIAL_INTERVAL = 1'd1;

    localparam logic [15:0] ALPHA_RESET    = 16'd655;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000000;

    localparam logic [2:0] ACT_IN_ORDER     = 3'd0;
    localparam logic [2:0] ACT_RESTORED     = 3'd1;
    localparam logic [2:0] ACT_DUPLICATE    = 3'd2;
    localparam logic [2:0] ACT_LATE_DROPPED = 3'd3;
    localparam logic [2:0] ACT_AFTER_LOSS   = 3'd4;
    localparam logic [2:0] ACT_WRONG_SIZE   = 3'd5;
    localparam logic [2:0] ACT_WRONG_FORMAT = 3'd6;

    // Classification of an item, settled in the evaluate step
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SIZE   = 2'd1;
    localparam logic [1:0] KIND_FORMAT = 2'd2;
    localparam logic [1:0] KIND_STATS  = 2'd3;

    // Datapath step commands
    typedef logic [3:0] t_step;
    localparam t_step STEP_NONE   = 4'd0;
    localparam t_step STEP_EVAL   = 4'd1;
    localparam t_step STEP_DIFF   = 4'd2;
    localparam t_step STEP_SQ     = 4'd3;
    localparam t_step STEP_TH     = 4'd4;
    localparam t_step STEP_TL     = 4'd5;
    localparam t_step STEP_AH     = 4'd6;
    localparam t_step STEP_AL     = 4'd7;
    localparam t_step STEP_DT     = 4'd8;
    localparam t_step STEP_SH     = 4'd9;
    localparam t_step STEP_SL     = 4'd10;
    localparam t_step STEP_FIN    = 4'd11;
    localparam t_step STEP_COMMIT = 4'd12;

    typedef struct packed {
        logic  load;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic stats;
        logic out_free;
    } t_sts;

    localparam logic signed [31:0] LOST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LOST_MIN = 32'sh8000_0000;

    localparam logic [31:0] DIST_HALF = 32'h8000_0000;
    localparam logic [31:0] DIST_NEG1 = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_NEG2 = 32'hFFFF_FFFE;

endpackage

### rtl/pjt_if.sv
// Valid/ready channel carrying one payload beat.
interface pjt_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

### rtl/packet_sequence_and_jitter_tracker.sv
// Top level of the packet sequence and jitter tracker.
//
//  channel  dir   beat                          accepted when
//  i_pkt    in    one parsed packet header      valid && ready
//  o_res    out   action, counters, statistics  valid && ready
//  i_cfg    in    register index and value      valid (ready always high)
//
//  A header whose size and format match the stream runs through the statistics
//  steps, in which the shared 32x32 multiplier does eight products in turn.
//  The first header and rejected headers skip the statistics steps.
//  A header is taken while the previous result still waits in the output
//  register; commit holds until that register is free.
//  Reset (i_rst_n low at a clock edge) forgets the stream and restores the registers.
module packet_sequence_and_jitter_tracker (
    input  logic i_clk,
    input  logic i_rst_n,
    pjt_if.sink   i_pkt,
    pjt_if.source o_res,
    pjt_if.sink   i_cfg
);
    import pjt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pjt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pjt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

### rtl/pjt_ctrl.sv
// Sequencer of the tracker: accepts a header and steps the datapath through it.
module pjt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pjt_if.sink           i_pkt,
    input  pjt_pkg::t_sts i_sts,
    output pjt_pkg::t_cmd o_cmd
);
    import pjt_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EVAL   = 4'd1;
    localparam logic [3:0] ST_DIFF   = 4'd2;
    localparam logic [3:0] ST_SQ     = 4'd3;
    localparam logic [3:0] ST_TH     = 4'd4;
    localparam logic [3:0] ST_TL     = 4'd5;
    localparam logic [3:0] ST_AH     = 4'd6;
    localparam logic [3:0] ST_AL     = 4'd7;
    localparam logic [3:0] ST_DT     = 4'd8;
    localparam logic [3:0] ST_SH     = 4'd9;
    localparam logic [3:0] ST_SL     = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;
    localparam logic [3:0] ST_COMMIT = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign i_pkt.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = STEP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_pkt.valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.step = STEP_EVAL;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                // kind is known now: skip the statistics for first or rejected headers
                if (i_sts.stats) begin
                    o_cmd.step = STEP_DIFF;
                    n_state    = ST_SQ;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_SQ: begin
                o_cmd.step = STEP_SQ;
                n_state    = ST_TH;
            end
            ST_TH: begin
                o_cmd.step = STEP_TH;
                n_state    = ST_TL;
            end
            ST_TL: begin
                o_cmd.step = STEP_TL;
                n_state    = ST_AH;
            end
            ST_AH: begin
                o_cmd.step = STEP_AH;
                n_state    = ST_AL;
            end
            ST_AL: begin
                o_cmd.step = STEP_AL;
                n_state    = ST_DT;
            end
            ST_DT: begin
                o_cmd.step = STEP_DT;
                n_state    = ST_SH;
            end
            ST_SH: begin
                o_cmd.step = STEP_SH;
                n_state    = ST_SL;
            end
            ST_SL: begin
                o_cmd.step = STEP_SL;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.step = STEP_FIN;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the result register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.step = STEP_COMMIT;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_commit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && !i_sts.out_free) |=> (r_state == ST_COMMIT))
        else $error("commit left while result register busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EVAL))
        else $error("accepted header not evaluated next");

    a_stats_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIFF && !i_sts.stats) |=> (r_state == ST_COMMIT))
        else $error("rejected or first header entered the statistics steps");

endmodule

### rtl/pjt_dpath.sv
// Datapath of the tracker: stream state, shared multiplier, classification, result register.
module pjt_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pjt_if.sink           i_pkt,
    pjt_if.source         o_res,
    pjt_if.sink           i_cfg,
    input  pjt_pkg::t_cmd i_cmd,
    output pjt_pkg::t_sts o_sts
);
    import pjt_pkg::*;

    // configuration
    logic [15:0] r_alpha;
    logic [31:0] r_init;

    // stream state
    logic               r_active;
    logic [10:0]        r_l_size;
    logic [8:0]         r_l_samples;
    logic [8:0]         r_l_channels;
    logic [2:0]         r_l_type;
    logic [23:0]        r_l_rate;
    logic [31:0]        r_expected;
    logic signed [31:0] r_lost;
    logic [63:0]        r_last;
    logic [47:0]        r_avg;
    logic [63:0]        r_var;
    logic               r_prev_full;
    logic               r_cur_full;

    // per item work registers
    t_pkt        r_pkt;
    logic [1:0]  r_kind;
    logic [31:0] r_u;
    logic        r_pos;
    logic [31:0] r_dt;
    logic [31:0] r_dv;
    logic [63:0] r_prod;
    logic [63:0] r_sq;
    logic [63:0] r_term;
    logic [63:0] r_s;
    logic [47:0] r_avgacc;
    logic [63:0] r_varacc;

    t_res r_out;
    logic r_out_valid;

    logic [16:0] w_beta;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [64:0] w_diff;
    logic [31:0] w_dt;
    logic [1:0]  w_kind;
    logic [47:0] w_dtq;
    logic [48:0] w_up;
    logic [47:0] w_down;
    logic [64:0] w_ssum;
    logic [33:0] w_lsum;

    logic [2:0]         n_action;
    logic [31:0]        n_expected;
    logic signed [31:0] n_lost;
    logic [47:0]        n_avg;
    logic [63:0]        n_var;
    logic [63:0]        n_last;
    logic               n_prev_full;
    logic               n_cur_full;

    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;
    assign o_sts.stats    = (r_kind == KIND_STATS);
    assign o_sts.out_free = !r_out_valid || o_res.ready;

    assign w_beta = 17'h1_0000 - {1'b0, r_alpha};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_init  <= INTERVAL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_EWMA_ALPHA:       r_alpha <= i_cfg.data.value[15:0];
                REG_INITIAL_INTERVAL: r_init  <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    // evaluate: clamp the arrival gap, sort the header
    assign w_diff = {1'b0, r_pkt.arrival_time_ns} - {1'b0, r_last};

    always_comb begin
        if (w_diff[64]) begin
            w_dt = '0;
        end else if (|w_diff[63:32]) begin
            w_dt = '1;
        end else begin
            w_dt = w_diff[31:0];
        end
        if (!r_active) begin
            w_kind = KIND_FIRST;
        end else if (r_pkt.payload_bytes != r_l_size) begin
            w_kind = KIND_SIZE;
        end else if (r_pkt.sample_count != r_l_samples || r_pkt.sample_type != r_l_type ||
                     r_pkt.channel_count != r_l_channels || r_pkt.rate_hz != r_l_rate) begin
            w_kind = KIND_FORMAT;
        end else begin
            w_kind = KIND_STATS;
        end
    end

    // |dt<<16 - avg|, both directions in parallel
    assign w_dtq  = {r_dt, 16'h0000};
    assign w_up   = {1'b0, w_dtq} - {1'b0, r_avg};
    assign w_down = r_avg - w_dtq;

    assign w_ssum = {1'b0, r_var} + {1'b0, r_term};

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.step)
            STEP_SQ: begin
                w_mul_a = r_dv;
                w_mul_b = r_dv;
            end
            STEP_TH: begin
                w_mul_a = r_prod[63:32];
                w_mul_b = {16'h0000, r_alpha};
            end
            STEP_TL: begin
                w_mul_a = r_sq[31:0];
                w_mul_b = {16'h0000, r_alpha};
            end
            STEP_AH: begin
                w_mul_a = {16'h0000, r_avg[47:32]};
                w_mul_b = {15'h0000, w_beta};
            end
            STEP_AL: begin
                w_mul_a = r_avg[31:0];
                w_mul_b = {15'h0000, w_beta};
            end
            STEP_DT: begin
                w_mul_a = r_dt;
                w_mul_b = {16'h0000, r_alpha};
            end
            STEP_SH: begin
                w_mul_a = r_s[63:32];
                w_mul_b = {15'h0000, w_beta};
            end
            STEP_SL: begin
                w_mul_a = r_s[31:0];
                w_mul_b = {15'h0000, w_beta};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_lsum = {{2{r_lost[31]}}, r_lost} + {2'b00, r_u};

    // commit: new stream state and the action code
    always_comb begin
        n_action    = ACT_IN_ORDER;
        n_expected  = r_expected;
        n_lost      = r_lost;
        n_avg       = r_avg;
        n_var       = r_var;
        n_last      = r_last;
        n_prev_full = r_prev_full;
        n_cur_full  = r_cur_full;
        case (r_kind)
            KIND_FIRST: begin
                n_expected  = r_pkt.seq_number + 32'd1;
                n_lost      = '0;
                n_avg       = {r_init, 16'h0000};
                n_var       = '0;
                n_last      = r_pkt.arrival_time_ns;
                n_prev_full = 1'b0;
                n_cur_full  = 1'b1;
            end
            KIND_SIZE: begin
                n_action = ACT_WRONG_SIZE;
            end
            KIND_FORMAT: begin
                n_action = ACT_WRONG_FORMAT;
            end
            default: begin
                n_avg  = r_avgacc;
                n_var  = r_varacc;
                n_last = r_pkt.arrival_time_ns;
                if (r_u == '0) begin
                    n_expected  = r_expected + 32'd1;
                    n_prev_full = r_cur_full;
                    n_cur_full  = 1'b1;
                end else if (!r_u[31] || (r_u == DIST_HALF && r_pos)) begin
                    n_action = ACT_AFTER_LOSS;
                    if (!w_lsum[33] && (|w_lsum[32:31])) begin
                        n_lost = LOST_MAX;
                    end else begin
                        n_lost = w_lsum[31:0];
                    end
                    n_expected  = r_pkt.seq_number + 32'd1;
                    n_prev_full = 1'b0;
                    n_cur_full  = 1'b1;
                end else if (r_u == DIST_NEG1 || (r_u == DIST_NEG2 && r_prev_full)) begin
                    n_action = ACT_DUPLICATE;
                end else if (r_u == DIST_NEG2) begin
                    n_action    = ACT_RESTORED;
                    n_lost      = (r_lost == LOST_MIN) ? LOST_MIN : r_lost - 32'sd1;
                    n_prev_full = 1'b1;
                end else begin
                    n_action = ACT_LATE_DROPPED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pkt <= i_pkt.data;
        end
        r_prod <= w_prod;
        case (i_cmd.step)
            STEP_EVAL: begin
                r_kind <= w_kind;
                r_dt   <= w_dt;
                r_u    <= r_pkt.seq_number - r_expected;
                r_pos  <= (r_pkt.seq_number >= r_expected);
            end
            STEP_DIFF: begin
                r_dv <= w_up[48] ? w_down[47:16] : w_up[47:16];
            end
            STEP_TH: begin
                r_sq <= r_prod;
            end
            STEP_TL: begin
                r_term <= {r_prod[47:0], 16'h0000};
            end
            STEP_AH: begin
                r_term <= r_term + {16'h0000, r_prod[63:16]};
            end
            STEP_AL: begin
                r_avgacc <= {r_prod[31:0], 16'h0000};
                r_s      <= w_ssum[64] ? '1 : w_ssum[63:0];
            end
            STEP_DT: begin
                r_avgacc <= r_avgacc + r_prod[63:16];
            end
            STEP_SH: begin
                r_avgacc <= r_avgacc + r_prod[47:0];
            end
            STEP_SL: begin
                r_varacc <= {r_prod[47:0], 16'h0000};
            end
            STEP_FIN: begin
                r_varacc <= r_varacc + {16'h0000, r_prod[63:16]};
            end
            STEP_COMMIT: begin
                r_expected  <= n_expected;
                r_lost      <= n_lost;
                r_avg       <= n_avg;
                r_var       <= n_var;
                r_last      <= n_last;
                r_prev_full <= n_prev_full;
                r_cur_full  <= n_cur_full;
                r_out.action            <= n_action;
                r_out.lost_total        <= n_lost;
                r_out.next_expected     <= n_expected;
                r_out.mean_interval     <= n_avg;
                r_out.interval_variance <= n_var;
                if (r_kind == KIND_FIRST) begin
                    r_l_size     <= r_pkt.payload_bytes;
                    r_l_samples  <= r_pkt.sample_count;
                    r_l_channels <= r_pkt.channel_count;
                    r_l_type     <= r_pkt.sample_type;
                    r_l_rate     <= r_pkt.rate_hz;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step == STEP_COMMIT) begin
                r_active    <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == STEP_COMMIT) |=> r_out_valid)
        else $error("committed result not presented");

    a_stats_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == STEP_SQ) |-> r_active)
        else $error("statistics update on an unlearned stream");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == STEP_COMMIT && (r_kind == KIND_SIZE || r_kind == KIND_FORMAT))
        |=> ($stable(r_expected) && $stable(r_lost) && $stable(r_var)))
        else $error("rejected header changed stream state");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == STEP_COMMIT && r_kind == KIND_FIRST)
        |=> (r_lost == '0 && r_var == '0 && r_cur_full && !r_prev_full))
        else $error("first header did not clear the counters");

endmodule

### test/packet_sequence_and_jitter_tracker_checker.sv
// Checker: predicts each tracker result from accepted headers and compares it with the output.
module packet_sequence_and_jitter_tracker_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pjt_if.monitor i_pkt,
    pjt_if.monitor i_res,
    pjt_if.monitor i_cfg,
    output int     o_mismatch_count,
    output int     o_reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pjt_pkg::*;

    logic [15:0]        alpha;
    logic [31:0]        start_interval;
    logic               stream_on;
    t_pkt               learned;
    logic [31:0]        want_seq;
    logic signed [31:0] lost;
    logic [63:0]        last_arrival;
    logic [47:0]        mean_q;
    logic [63:0]        spread;
    logic               prev_full;
    logic               cur_full;

    t_res reports[$];
    int   mismatches;
    int   beat_no;

    // floor(x * a / 65536), exact for a up to 65536
    function automatic logic [63:0] scale_q16(input logic [63:0] x, input logic [16:0] a);
        logic [80:0] p;
        p = x * a;
        return p[79:16];
    endfunction

    function automatic void bump_lost(input longint signed delta);
        longint signed v;
        v = longint'(lost) + delta;
        if (v > longint'(LOST_MAX)) begin
            v = longint'(LOST_MAX);
        end else if (v < longint'(LOST_MIN)) begin
            v = longint'(LOST_MIN);
        end
        lost = v[31:0];
    endfunction

    function automatic void update_jitter(input logic [63:0] t);
        logic [16:0] a;
        logic [16:0] b;
        logic [63:0] dt;
        logic [47:0] dtq;
        logic [47:0] m;
        logic [31:0] dv;
        logic [63:0] sq;
        logic [63:0] term;
        logic [64:0] s;
        logic [65:0] mix;
        a = {1'b0, alpha};
        b = 17'h1_0000 - a;
        dt = '0;
        if (t >= last_arrival) begin
            dt = t - last_arrival;
            if (dt > 64'hFFFF_FFFF) begin
                dt = 64'hFFFF_FFFF;
            end
        end
        dtq = {dt[31:0], 16'h0};
        m = (dtq >= mean_q) ? dtq - mean_q : mean_q - dtq;
        dv = m[47:16];
        sq = dv * dv;
        term = scale_q16(sq, a);
        s = spread + term;
        // saturate the sum before the decay
        spread = scale_q16(s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0], b);
        mix = a * dtq + b * mean_q;
        mean_q = mix[63:16];
        last_arrival = t;
    endfunction

    function automatic t_res track_header(input t_pkt h);
        t_res        r;
        logic [31:0] u;
        logic        ahead;
        r.action = ACT_IN_ORDER;
        if (!stream_on) begin
            stream_on = 1'b1;
            learned = h;
            want_seq = h.seq_number;
            lost = '0;
            last_arrival = h.arrival_time_ns;
            mean_q = {start_interval, 16'h0};
            spread = '0;
            prev_full = 1'b0;
            cur_full = 1'b0;
        end else if (h.payload_bytes != learned.payload_bytes) begin
            r.action = ACT_WRONG_SIZE;
        end else if (h.sample_count != learned.sample_count
                || h.sample_type != learned.sample_type
                || h.channel_count != learned.channel_count
                || h.rate_hz != learned.rate_hz) begin
            r.action = ACT_WRONG_FORMAT;
        end else begin
            update_jitter(h.arrival_time_ns);
        end

        if (r.action == ACT_IN_ORDER) begin
            if (h.seq_number == want_seq) begin
                want_seq = want_seq + 1;
                prev_full = cur_full;
                cur_full = 1'b1;
            end else begin
                u = h.seq_number - want_seq;
                // exactly half the range: the unsigned order decides
                if (u == DIST_HALF) begin
                    ahead = (h.seq_number >= want_seq);
                end else begin
                    ahead = (u < DIST_HALF);
                end
                if (ahead) begin
                    bump_lost({32'd0, u});
                    want_seq = h.seq_number + 1;
                    prev_full = 1'b0;
                    cur_full = 1'b1;
                    r.action = ACT_AFTER_LOSS;
                end else if (u == DIST_NEG1 || (u == DIST_NEG2 && prev_full)) begin
                    r.action = ACT_DUPLICATE;
                end else if (u == DIST_NEG2) begin
                    bump_lost(-1);
                    prev_full = 1'b1;
                    r.action = ACT_RESTORED;
                end else begin
                    r.action = ACT_LATE_DROPPED;
                end
            end
        end

        r.lost_total = lost;
        r.next_expected = want_seq;
        r.mean_interval = mean_q;
        r.interval_variance = spread;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            alpha = ALPHA_RESET;
            start_interval = INTERVAL_RESET;
            stream_on = 1'b0;
            learned = '0;
            want_seq = '0;
            lost = '0;
            last_arrival = '0;
            mean_q = '0;
            spread = '0;
            prev_full = 1'b0;
            cur_full = 1'b0;
            reports.delete();
            mismatches = 0;
            beat_no = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    REG_EWMA_ALPHA:       alpha = i_cfg.data.value[15:0];
                    REG_INITIAL_INTERVAL: start_interval = i_cfg.data.value;
                    default: ;
                endcase
            end
            if (i_pkt.valid && i_pkt.ready) begin
                reports.push_back(track_header(i_pkt.data));
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no header pending: action %0d", beat_no,
                                 got.action);
                    end
                end else begin
                    want = reports.pop_front();
                    if (got.action !== want.action || got.lost_total !== want.lost_total
                            || got.next_expected !== want.next_expected
                            || got.mean_interval !== want.mean_interval
                            || got.interval_variance !== want.interval_variance) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d expected: action %0d lost %0d next %h mean %h var %h",
                                     beat_no, want.action, want.lost_total, want.next_expected,
                                     want.mean_interval, want.interval_variance);
                            $display("result %0d actual:   action %0d lost %0d next %h mean %h var %h",
                                     beat_no, got.action, got.lost_total, got.next_expected,
                                     got.mean_interval, got.interval_variance);
                        end
                    end
                end
                beat_no++;
            end
        end
        o_mismatch_count <= mismatches;
        o_reports_pending <= reports.size();
    end

endmodule

### test/packet_sequence_and_jitter_tracker_test.sv
// Testbench top: drives headers and register writes into the tracker and gives the verdict.
module packet_sequence_and_jitter_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pjt_pkg::*;

    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pjt_if #(.T(t_pkt)) pkt_ch ();
    pjt_if #(.T(t_res)) res_ch ();
    pjt_if #(.T(t_cfg)) cfg_ch ();

    int mismatch_count;
    int reports_pending;

    int tx_idle_pct = 31;
    int rx_idle_pct = 50;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // stimulus view of the stream: learned format, next sequence, arrival clock
    t_pkt        stream_fmt;
    logic [31:0] seq_next;
    logic [63:0] clock_ns;

    always #4ns i_clk = ~i_clk;

    packet_sequence_and_jitter_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    packet_sequence_and_jitter_tracker_checker tracker_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pkt             (pkt_ch),
        .i_res             (res_ch),
        .i_cfg             (cfg_ch),
        .o_mismatch_count  (mismatch_count),
        .o_reports_pending (reports_pending)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        do begin
            @(posedge i_clk);
            if (!i_rst_n || (pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end while (quiet_cycles < QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Leave valid high after the beat; the next call lowers or reuses it.
    task automatic send_pkt(input t_pkt p);
        while ($urandom_range(99) < tx_idle_pct) begin
            pkt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.data <= p;
        do @(posedge i_clk); while (!(pkt_ch.valid && pkt_ch.ready));
        @(negedge i_clk);
    endtask

    task automatic send_fmt(input logic [31:0] seq, input logic [63:0] t);
        t_pkt p;
        p = stream_fmt;
        p.seq_number = seq;
        p.arrival_time_ns = t;
        send_pkt(p);
    endtask

    task automatic program_regs(input logic [15:0] alpha_value, input logic [31:0] interval);
        t_cfg beat [2];
        beat[0].index = REG_EWMA_ALPHA;
        beat[0].value = {16'($urandom), alpha_value};
        beat[1].index = REG_INITIAL_INTERVAL;
        beat[1].value = interval;
        foreach (beat[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data <= beat[k];
            do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering, wait for every result, then let the pipeline settle.
    task automatic drain_block();
        pkt_ch.valid <= 1'b0;
        do @(negedge i_clk); while (reports_pending != 0);
        repeat (16) @(negedge i_clk);
    endtask

    function automatic logic [63:0] next_arrival();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            clock_ns = clock_ns + $urandom_range(200, 3_000_000);
        end else if (pick < 80) begin
            clock_ns = clock_ns + $urandom_range(0, 64);
        end else if (pick < 87) begin
            clock_ns = clock_ns - $urandom_range(1, 100_000);
        end else if (pick < 93) begin
            clock_ns = clock_ns + {$urandom_range(1, 255), $urandom};
        end else if (pick < 97) begin
            clock_ns = clock_ns + $urandom;
        end
        return clock_ns;
    endfunction

    task automatic send_random();
        t_pkt        p;
        logic [31:0] seq;
        int          pick;
        p = stream_fmt;
        p.arrival_time_ns = next_arrival();
        pick = $urandom_range(99);
        if (pick < 55) begin
            seq = seq_next;
        end else if (pick < 63) begin
            seq = seq_next + $urandom_range(1, 4);
        end else if (pick < 66) begin
            seq = seq_next + $urandom_range(5, 32'h7FFF_FFFF);
        end else if (pick < 74) begin
            seq = seq_next - 1;
        end else if (pick < 82) begin
            seq = seq_next - 2;
        end else if (pick < 87) begin
            if ($urandom_range(3) == 0) begin
                seq = seq_next - $urandom_range(3, 32'h7FFF_FFFF);
            end else begin
                seq = seq_next - $urandom_range(3, 60);
            end
        end else if (pick < 93) begin
            // noise: every field random, size forced off the stream
            seq = $urandom;
            p.arrival_time_ns = {$urandom, $urandom};
            p.payload_bytes = stream_fmt.payload_bytes ^ 11'($urandom_range(1, 2047));
            p.sample_count = 9'($urandom);
            p.channel_count = 9'($urandom);
            p.sample_type = 3'($urandom);
            p.rate_hz = 24'($urandom);
        end else begin
            seq = $urandom;
            case ($urandom_range(3))
                0: p.sample_count = stream_fmt.sample_count ^ 9'($urandom_range(1, 511));
                1: p.channel_count = stream_fmt.channel_count ^ 9'($urandom_range(1, 511));
                2: p.sample_type = stream_fmt.sample_type ^ 3'($urandom_range(1, 7));
                default: p.rate_hz = stream_fmt.rate_hz ^ 24'($urandom_range(1, 24'hFF_FFFF));
            endcase
        end
        p.seq_number = seq;
        // in order and losses move the expected sequence
        if (pick < 66) begin
            seq_next = seq + 1;
        end
        send_pkt(p);
    endtask

    initial begin
        logic [31:0] s;
        t_pkt        p;
        logic [31:0] first_interval;
        logic [15:0] phase_alpha;

        i_rst_n = 1'b0;
        pkt_ch.valid = 1'b0;
        pkt_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        case ($urandom_range(3))
            0: first_interval = '0;
            1: first_interval = '1;
            2: first_interval = INTERVAL_RESET;
            default: first_interval = $urandom;
        endcase
        @(negedge i_clk);
        program_regs(ALPHA_RESET, first_interval);

        stream_fmt = '0;
        stream_fmt.payload_bytes = 11'($urandom);
        stream_fmt.sample_count = 9'($urandom);
        stream_fmt.channel_count = 9'($urandom);
        stream_fmt.sample_type = 3'($urandom);
        stream_fmt.rate_hz = 24'($urandom);
        seq_next = $urandom;
        clock_ns = {$urandom, $urandom};

        // learn the stream, then one in order to fill the previous slot
        send_fmt(seq_next, clock_ns);
        seq_next = seq_next + 1;
        clock_ns = clock_ns + 1000;
        send_fmt(seq_next, clock_ns);
        seq_next = seq_next + 1;

        // rejects: size, each format field, then size and format together
        for (int k = 0; k < 6; k++) begin
            p = stream_fmt;
            p.seq_number = seq_next;
            p.arrival_time_ns = clock_ns + 500;
            case (k)
                0: p.payload_bytes = ~stream_fmt.payload_bytes;
                1: p.sample_count = ~stream_fmt.sample_count;
                2: p.channel_count = ~stream_fmt.channel_count;
                3: p.sample_type = ~stream_fmt.sample_type;
                4: p.rate_hz = ~stream_fmt.rate_hz;
                default: begin
                    p.payload_bytes = ~stream_fmt.payload_bytes;
                    p.rate_hz = ~stream_fmt.rate_hz;
                end
            endcase
            send_pkt(p);
        end

        clock_ns = clock_ns + 900;
        send_fmt(seq_next - 1, clock_ns);
        send_fmt(seq_next - 2, clock_ns);
        s = seq_next + 3;
        seq_next = s + 1;
        send_fmt(s, clock_ns);
        send_fmt(seq_next - 2, clock_ns);
        send_fmt(seq_next - 2, clock_ns);
        send_fmt(seq_next - 5, clock_ns);

        // arrival earlier, the same, and far later than the last one
        clock_ns = clock_ns - 5000;
        send_fmt(seq_next, clock_ns);
        seq_next = seq_next + 1;
        send_fmt(seq_next, clock_ns);
        seq_next = seq_next + 1;
        clock_ns = clock_ns + 64'h2_0000_0000;
        send_fmt(seq_next, clock_ns);
        seq_next = seq_next + 1;

        // half-range distance from both sides of the unsigned order
        clock_ns = clock_ns + 700;
        s = seq_next + DIST_HALF;
        if (s >= seq_next) begin
            seq_next = s + 1;
        end
        send_fmt(s, clock_ns);
        s = seq_next + 32'h7FFF_FFFF;
        seq_next = s + 1;
        send_fmt(s, clock_ns);
        s = seq_next + DIST_HALF;
        if (s >= seq_next) begin
            seq_next = s + 1;
        end
        send_fmt(s, clock_ns);

        // restore after the lost count has saturated
        s = seq_next + 1;
        seq_next = s + 1;
        send_fmt(s, clock_ns);
        send_fmt(seq_next - 2, clock_ns);

        for (int ph = 0; ph < 6; ph++) begin
            drain_block();
            tx_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 50 : 0;
            rx_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 31 : 0;
            case (ph)
                0: phase_alpha = 16'($urandom_range(1, 2000));
                1: phase_alpha = '0;
                2: phase_alpha = '1;
                3: phase_alpha = 16'h8000;
                4: phase_alpha = 16'($urandom);
                default: phase_alpha = 16'($urandom_range(1, 64));
            endcase
            program_regs(phase_alpha, $urandom);
            // stall the output for a long stretch while headers keep coming
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_random();
        end

        drain_block();
        if (mismatch_count == 0 && reports_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pjt_pkg.sv
rtl/pjt_if.sv
rtl/pjt_ctrl.sv
rtl/pjt_dpath.sv
rtl/packet_sequence_and_jitter_tracker.sv
test/packet_sequence_and_jitter_tracker_checker.sv
test/packet_sequence_and_jitter_tracker_test.sv
